// ===== design/sofp_pkg.sv =====
// Shared constants, types and control structs for the frame parser.
package sofp_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int IDX_W       = 5;
    localparam int EVENT_W     = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CRC_W       = 16;
    localparam int BIT_CNT_W   = $clog2(BYTE_W);

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_DEPTH = 32;
    localparam int CAPACITY    = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
    localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;
    localparam logic [LEN_W-1:0]  LIMIT_RESET = LEN_W'(32);
    localparam logic [LEN_W-1:0]  CAP_LEN     = LEN_W'(CAPACITY);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_CMD,
        PH_PAY,
        PH_CRCH,
        PH_CRCL
    } t_phase;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EMIT_RD,
        CTL_EMIT_LD
    } t_ctl;

    typedef enum logic [EVENT_W-1:0] {
        EV_GOOD   = 2'd0,
        EV_BADCRC = 2'd1,
        EV_BADLEN = 2'd2
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE   = 1'b0,
        REG_LENGTH_LIMIT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic              start;
        logic              init;
        logic [BYTE_W-1:0] data;
    } t_crc_cmd;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

endpackage

// ===== design/sofp_if.sv =====
// Channel interfaces: received byte, result word and configuration write.
interface sofp_byte_if;
    import sofp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sofp_res_if;
    import sofp_pkg::*;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [LEN_W-1:0]   frame_length;
    logic [BYTE_W-1:0]  command;
    logic [BYTE_W-1:0]  payload_byte;
    logic [IDX_W-1:0]   byte_index;
    logic               payload_valid;
    logic               last;
    modport source (output valid, output event_res, output frame_length, output command,
                    output payload_byte, output byte_index, output payload_valid,
                    output last, input ready);
    modport sink   (input valid, input event_res, input frame_length, input command,
                    input payload_byte, input byte_index, input payload_valid,
                    input last, output ready);
endinterface

interface sofp_cfg_if;
    import sofp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [BYTE_W-1:0]    wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/sofp_crc_serial.sv =====
// Bit-serial CRC-16 engine: one message bit per cycle from a byte shift register.
module sofp_crc_serial (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sofp_pkg::t_crc_cmd          i_cmd,
    output logic [sofp_pkg::CRC_W-1:0]  o_crc,
    output logic                        o_busy
);
    import sofp_pkg::*;

    logic [CRC_W-1:0]     r_crc;
    logic [BYTE_W-1:0]    r_shift;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [CRC_W-1:0]     crc_seed;

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic din);
        logic fb;
        fb = crc[CRC_W-1] ^ din;
        return {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    endfunction

    assign crc_seed = i_cmd.init ? CRC_INIT : r_crc;

    // First bit is taken in the start cycle, the remaining seven follow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_crc  <= crc_step(crc_seed, i_cmd.data[BYTE_W-1]);
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_crc <= crc_step(r_crc, r_shift[BYTE_W-1]);
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == BIT_CNT_W'(BYTE_W - 2)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_shift <= {i_cmd.data[BYTE_W-2:0], 1'b0};
        end else if (r_busy) begin
            r_shift <= {r_shift[BYTE_W-2:0], 1'b0};
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = r_busy;

endmodule

// ===== design/sofp_store.sv =====
// Payload buffer: one write port, one registered read port.
module sofp_store (
    input  logic                         i_clk,
    input  sofp_pkg::t_store_wr          i_wr,
    input  logic [sofp_pkg::ADDR_W-1:0]  i_raddr,
    output logic [sofp_pkg::BYTE_W-1:0]  o_rdata
);
    import sofp_pkg::*;

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sof_length_frame_parser_crc16.sv =====
// Top level of the start-of-frame / length deframer with CRC-16 check.
//
// Usage: received bytes enter on i_in, one word per handshake. Frames are
// start byte, length, command, payload, CRC high, CRC low; the CRC-16
// (poly 0x1021, init 0xFFFF) covers length, command and payload.
// Results leave on o_res: one bad-length or bad-CRC word, or a good frame
// as one word per payload byte with last set on the final one (a single
// word for an empty frame). i_cfg writes start_byte (0) and length_limit (1)
// and is always ready; write it only while the block is idle.
// Throughput: command, payload and in-range length bytes each hold ready low
// after the accept while the bit-serial CRC shift register works through the
// byte. Start, hunting and CRC bytes are taken one per cycle.
// Results: after the CRC low or a bad length byte the emitter reads the
// registered payload buffer, then loads the output register, once per result
// while the receiver keeps up. No byte is taken during a result run.
// Stall: a waiting result holds in the output register; a new byte is still
// accepted while a lone result waits.
// Reset: synchronous active low; the parser hunts for a start byte and the
// registers return to 0xAA and 32. The payload buffer needs no clearing.
module sof_length_frame_parser_crc16 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sofp_byte_if.sink     i_in,
    sofp_res_if.source    o_res,
    sofp_cfg_if.sink      i_cfg
);
    import sofp_pkg::*;

    // configuration
    logic [BYTE_W-1:0] r_start_byte;
    logic [LEN_W-1:0]  r_length_limit;

    // parser state
    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_held_len;
    logic [BYTE_W-1:0] r_held_cmd;
    logic [LEN_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_crc_high;

    // emitter state
    t_ctl              r_ctl, n_ctl;
    t_event            r_emit_kind;
    logic [IDX_W-1:0]  r_idx;

    // output register
    logic               r_res_valid;
    logic [EVENT_W-1:0] r_res_event;
    logic [LEN_W-1:0]   r_res_len;
    logic [BYTE_W-1:0]  r_res_cmd;
    logic [BYTE_W-1:0]  r_res_byte;
    logic [IDX_W-1:0]   r_res_idx;
    logic               r_res_pvalid;
    logic               r_res_last;

    logic [BYTE_W-1:0] rx;
    logic              in_ready;
    logic              in_acc;
    logic [LEN_W-1:0]  lim_eff;
    logic              len_bad;
    logic              crc_bad;
    logic [LEN_W-1:0]  count_inc;
    logic              emit_go;
    t_event            emit_kind;
    logic              slot_free;
    logic              res_load;
    logic              emit_pvalid;
    logic              emit_last;

    t_crc_cmd          crc_cmd;
    t_store_wr         store_wr;
    logic [CRC_W-1:0]  crc_value;
    logic              crc_busy;
    logic [BYTE_W-1:0] store_rdata;

    sofp_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (crc_cmd),
        .o_crc   (crc_value),
        .o_busy  (crc_busy)
    );

    sofp_store u_store (
        .i_clk   (i_clk),
        .i_wr    (store_wr),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (store_rdata)
    );

    assign rx        = i_in.rx_byte;
    assign in_ready  = (r_ctl == CTL_IDLE) && !crc_busy;
    assign in_acc    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    assign lim_eff   = (r_length_limit > CAP_LEN) ? CAP_LEN : r_length_limit;
    assign len_bad   = rx > BYTE_W'(lim_eff);
    assign crc_bad   = {r_crc_high, rx} != crc_value;
    assign count_inc = r_count + 1'b1;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= START_RESET;
            r_length_limit <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.reg_index))
                REG_START_BYTE:   r_start_byte   <= i_cfg.wdata;
                REG_LENGTH_LIMIT: r_length_limit <= i_cfg.wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // parser next phase
    always_comb begin
        n_phase = r_phase;
        if (in_acc) begin
            case (r_phase)
                PH_LEN:  n_phase = len_bad ? PH_HUNT : PH_CMD;
                PH_CMD:  n_phase = (r_held_len != '0) ? PH_PAY : PH_CRCH;
                PH_PAY:  n_phase = (count_inc >= r_held_len) ? PH_CRCH : PH_PAY;
                PH_CRCH: n_phase = PH_CRCL;
                PH_CRCL: n_phase = PH_HUNT;
                default: n_phase = (rx == r_start_byte) ? PH_LEN : PH_HUNT;
            endcase
        end
    end

    // parser outputs
    always_comb begin
        crc_cmd.start = 1'b0;
        crc_cmd.init  = (r_phase == PH_LEN);
        crc_cmd.data  = rx;
        store_wr.we   = 1'b0;
        store_wr.addr = r_count[ADDR_W-1:0];
        store_wr.data = rx;
        emit_go       = 1'b0;
        emit_kind     = EV_GOOD;
        if (in_acc) begin
            case (r_phase)
                PH_LEN: begin
                    crc_cmd.start = !len_bad;
                    emit_go       = len_bad;
                    emit_kind     = EV_BADLEN;
                end
                PH_CMD: begin
                    crc_cmd.start = 1'b1;
                end
                PH_PAY: begin
                    crc_cmd.start = 1'b1;
                    store_wr.we   = 1'b1;
                end
                PH_CRCL: begin
                    emit_go   = 1'b1;
                    emit_kind = crc_bad ? EV_BADCRC : EV_GOOD;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_held_len <= '0;
            r_held_cmd <= '0;
            r_count    <= '0;
            r_crc_high <= '0;
        end else begin
            r_phase <= n_phase;
            if (in_acc) begin
                case (r_phase)
                    PH_LEN: begin
                        if (!len_bad) begin
                            r_held_len <= rx[LEN_W-1:0];
                        end
                    end
                    PH_CMD: begin
                        r_held_cmd <= rx;
                        r_count    <= '0;
                    end
                    PH_PAY:  r_count    <= count_inc;
                    PH_CRCH: r_crc_high <= rx;
                    default: ;
                endcase
            end
        end
    end

    // result emitter
    assign slot_free   = !r_res_valid || o_res.ready;
    assign emit_pvalid = (r_emit_kind == EV_GOOD) && (r_held_len != '0);
    assign emit_last   = !emit_pvalid || ((LEN_W'(r_idx) + 1'b1) == r_held_len);

    always_comb begin
        n_ctl = r_ctl;
        case (r_ctl)
            CTL_IDLE:    n_ctl = emit_go ? CTL_EMIT_RD : CTL_IDLE;
            CTL_EMIT_RD: n_ctl = CTL_EMIT_LD;
            CTL_EMIT_LD: begin
                if (slot_free) begin
                    n_ctl = emit_last ? CTL_IDLE : CTL_EMIT_RD;
                end
            end
            default:     n_ctl = CTL_IDLE;
        endcase
    end

    always_comb begin
        res_load = (r_ctl == CTL_EMIT_LD) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= CTL_IDLE;
            r_emit_kind <= EV_GOOD;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_ctl <= n_ctl;
            if (emit_go) begin
                r_emit_kind <= emit_kind;
                r_idx       <= '0;
            end else if (res_load && !emit_last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // hold the word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_event  <= r_emit_kind;
            r_res_len    <= (r_emit_kind == EV_GOOD) ? r_held_len : '0;
            r_res_cmd    <= (r_emit_kind == EV_GOOD) ? r_held_cmd : '0;
            r_res_byte   <= emit_pvalid ? store_rdata : '0;
            r_res_idx    <= emit_pvalid ? r_idx : '0;
            r_res_pvalid <= emit_pvalid;
            r_res_last   <= emit_last;
        end
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.event_res     = r_res_event;
    assign o_res.frame_length  = r_res_len;
    assign o_res.command       = r_res_cmd;
    assign o_res.payload_byte  = r_res_byte;
    assign o_res.byte_index    = r_res_idx;
    assign o_res.payload_valid = r_res_pvalid;
    assign o_res.last          = r_res_last;

endmodule
